// ----- rtl/ilie_pkg.sv -----
// Package with the shared constants, codes and types of the indexed list.
`default_nettype none
package ilie_pkg;

	localparam int CAPACITY = 64;
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int INDEX_W = 6;
	localparam int VALUE_W = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W = 7;
	localparam int KIND_W = 2;
	localparam int S_DATA_W = 40;
	localparam int M_DATA_W = 48;

	typedef enum logic [KIND_W-1:0] {
		KIND_APPEND = 2'd0,
		KIND_INSERT = 2'd1,
		KIND_ERASE = 2'd2,
		KIND_READ = 2'd3
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK = 2'd0,
		STATUS_BAD_INDEX = 2'd1,
		STATUS_FULL = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD = 2'd0,
		CELL_INSERT = 2'd1,
		CELL_ERASE = 2'd2
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic [CNT_W-1:0] idx;
		logic [VALUE_W-1:0] value;
	} cell_cmd_t;

endpackage
`default_nettype wire

// ----- rtl/indexed_list_insert_erase_top.sv -----
// Top level of the indexed list: command decode, row of list cells and result register.
`default_nettype none
// The block keeps an ordered list of up to 64 signed words in a row of cells, one entry per
// cell. Every transaction carries one operation (append, insert at index, erase at index or
// read at index) and returns exactly one result with the read data, a status and the count
// held afterwards. All cells compare their position with the index in the same cycle and
// shift together, so each operation is done as it is accepted and its result is offered in the next cycle.
// A new transaction is accepted in any cycle in which the result register is empty or its
// result is taken in that same cycle; while a result waits, the input stalls.
// The list is empty after reset and needs no clearing pass.
module indexed_list_insert_erase_top
	import ilie_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	// Fields from bit 0 up: index[5:0], value[31:0], zero padding.
	input wire logic [S_DATA_W-1:0] s_tdata,
	// Fields from bit 0 up: kind[1:0].
	input wire logic [KIND_W-1:0] s_tuser,
	output logic m_tvalid,
	input wire logic m_tready,
	// Fields from bit 0 up: read_value[31:0], status[1:0], count[6:0], zero padding.
	output logic [M_DATA_W-1:0] m_tdata
);

	logic accept;
	logic [INDEX_W-1:0] index;
	logic [VALUE_W-1:0] value;
	kind_t kind;
	logic [CNT_W-1:0] idx_ext;
	logic [CNT_W-1:0] fill_count_q;
	logic [CNT_W-1:0] fill_count_d;
	cell_cmd_t cmd;
	status_t status_d;
	logic read_ok;
	logic [VALUE_W-1:0] rd_or;
	logic [VALUE_W-1:0] entry_w [CAPACITY];
	logic [VALUE_W-1:0] rd_w [CAPACITY];
	logic m_tvalid_q;
	logic [VALUE_W-1:0] read_value_q;
	status_t status_q;
	logic [CNT_W-1:0] count_q;

	assign index = s_tdata[INDEX_W-1:0];
	assign value = s_tdata[INDEX_W+VALUE_W-1:INDEX_W];
	assign kind = kind_t'(s_tuser);
	assign idx_ext = CNT_W'(index);
	assign s_tready = !m_tvalid_q || m_tready;
	assign accept = s_tvalid && s_tready;

	always_comb begin
		cmd.op = CELL_HOLD;
		cmd.idx = idx_ext;
		cmd.value = value;
		status_d = STATUS_OK;
		read_ok = 1'b0;
		fill_count_d = fill_count_q;
		case (kind)
			KIND_APPEND: begin
				cmd.idx = fill_count_q;
				if (fill_count_q >= CNT_W'(CAPACITY)) begin
					status_d = STATUS_FULL;
				end else begin
					cmd.op = CELL_INSERT;
					fill_count_d = fill_count_q + 1'b1;
				end
			end
			KIND_INSERT: begin
				if (idx_ext > fill_count_q) begin
					status_d = STATUS_BAD_INDEX;
				end else if (fill_count_q >= CNT_W'(CAPACITY)) begin
					status_d = STATUS_FULL;
				end else begin
					cmd.op = CELL_INSERT;
					fill_count_d = fill_count_q + 1'b1;
				end
			end
			KIND_ERASE: begin
				if (idx_ext >= fill_count_q) begin
					status_d = STATUS_BAD_INDEX;
				end else begin
					cmd.op = CELL_ERASE;
					fill_count_d = fill_count_q - 1'b1;
				end
			end
			default: begin
				if (idx_ext >= fill_count_q) begin
					status_d = STATUS_BAD_INDEX;
				end else begin
					read_ok = 1'b1;
				end
			end
		endcase
		if (!accept) begin
			cmd.op = CELL_HOLD;
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [VALUE_W-1:0] left_w;
		logic [VALUE_W-1:0] right_w;
		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = entry_w[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = entry_w[i+1];
		end
		ilie_cell u_cell (
			.clk(clk),
			.pos(IDX_W'(i)),
			.cmd(cmd),
			.left(left_w),
			.right(right_w),
			.entry(entry_w[i]),
			.rd(rd_w[i])
		);
	end

	always_comb begin
		rd_or = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			rd_or = rd_or | rd_w[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_count_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (accept) begin
				fill_count_q <= fill_count_d;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			read_value_q <= read_ok ? rd_or : '0;
			status_q <= status_d;
			count_q <= fill_count_d;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = {
		(M_DATA_W - VALUE_W - STATUS_W - COUNT_W)'(0),
		COUNT_W'(count_q),
		status_q,
		read_value_q
	};

endmodule
`default_nettype wire

// ----- rtl/ilie_cell.sv -----
// One list cell: holds one entry and shifts with its neighbors on insert or erase.
`default_nettype none
module ilie_cell
	import ilie_pkg::*;
(
	input wire logic clk,
	input wire logic [IDX_W-1:0] pos,
	input wire cell_cmd_t cmd,
	input wire logic [VALUE_W-1:0] left,
	input wire logic [VALUE_W-1:0] right,
	output logic [VALUE_W-1:0] entry,
	output logic [VALUE_W-1:0] rd
);

	logic [VALUE_W-1:0] entry_q;
	logic [CNT_W-1:0] pos_ext;

	assign pos_ext = CNT_W'(pos);
	assign entry = entry_q;
	assign rd = (pos_ext == cmd.idx) ? entry_q : '0;

	always_ff @(posedge clk) begin
		case (cmd.op)
			CELL_INSERT: begin
				if (pos_ext > cmd.idx) begin
					entry_q <= left;
				end else if (pos_ext == cmd.idx) begin
					entry_q <= cmd.value;
				end
			end
			CELL_ERASE: begin
				if (pos_ext >= cmd.idx) begin
					entry_q <= right;
				end
			end
			default: begin
				entry_q <= entry_q;
			end
		endcase
	end

endmodule
`default_nettype wire

// ----- bench/list_checker.sv -----
// Checker that predicts each list result from the accepted commands and compares it.
`timescale 1ns / 100ps
module list_checker
	import ilie_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	input wire logic s_tready,
	// Fields from bit 0 up: index[5:0], value[31:0], zero padding.
	input wire logic [S_DATA_W-1:0] s_tdata,
	// Fields from bit 0 up: kind[1:0].
	input wire logic [KIND_W-1:0] s_tuser,
	input wire logic m_tvalid,
	input wire logic m_tready,
	// Fields from bit 0 up: read_value[31:0], status[1:0], count[6:0], zero padding.
	input wire logic [M_DATA_W-1:0] m_tdata,
	output int error_count,
	output int outstanding,
	output logic [COUNT_W-1:0] held_count
);

	typedef struct {
		logic [VALUE_W-1:0] read_value;
		status_t status;
		logic [COUNT_W-1:0] count;
	} list_result_t;

	logic [VALUE_W-1:0] cells [CAPACITY];
	int held;
	int mismatches;
	list_result_t pending_results [$];

	function automatic list_result_t predict_list_op(kind_t op, logic [INDEX_W-1:0] pos,
			logic [VALUE_W-1:0] word);
		list_result_t r;
		int i;
		r.read_value = '0;
		r.status = STATUS_OK;
		case (op)
			KIND_APPEND: begin
				if (held >= CAPACITY) begin
					r.status = STATUS_FULL;
				end else begin
					cells[held] = word;
					held++;
				end
			end
			KIND_INSERT: begin
				if (int'(pos) > held) begin
					r.status = STATUS_BAD_INDEX;
				end else if (held >= CAPACITY) begin
					r.status = STATUS_FULL;
				end else begin
					for (i = held; i > int'(pos); i--)
						cells[i] = cells[i - 1];
					cells[pos] = word;
					held++;
				end
			end
			KIND_ERASE: begin
				if (int'(pos) >= held) begin
					r.status = STATUS_BAD_INDEX;
				end else begin
					for (i = int'(pos); i + 1 < held; i++)
						cells[i] = cells[i + 1];
					held--;
				end
			end
			default: begin
				if (int'(pos) >= held)
					r.status = STATUS_BAD_INDEX;
				else
					r.read_value = cells[pos];
			end
		endcase
		r.count = COUNT_W'(held);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		list_result_t want;
		logic [VALUE_W-1:0] got_value;
		logic [STATUS_W-1:0] got_status;
		logic [COUNT_W-1:0] got_count;
		if (!arst_n) begin
			held = 0;
			mismatches = 0;
			pending_results.delete();
			held_count <= '0;
			outstanding <= 0;
			error_count <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got_value = m_tdata[31:0];
				got_status = m_tdata[33:32];
				got_count = m_tdata[40:34];
				if (pending_results.size() == 0) begin
					$error("result transaction with no pending expectation: %h", m_tdata);
					mismatches++;
				end else begin
					want = pending_results.pop_front();
					if (got_value !== want.read_value) begin
						$error("read_value: expected %0d, got %0d",
							$signed(want.read_value), $signed(got_value));
						mismatches++;
					end
					if (got_status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, got_status);
						mismatches++;
					end
					if (got_count !== want.count) begin
						$error("count: expected %0d, got %0d", want.count, got_count);
						mismatches++;
					end
				end
			end
			if (s_tvalid && s_tready)
				pending_results.insert(pending_results.size(),
					predict_list_op(kind_t'(s_tuser),
					s_tdata[INDEX_W-1:0], s_tdata[INDEX_W+VALUE_W-1:INDEX_W]));
			held_count <= COUNT_W'(held);
			outstanding <= pending_results.size();
			error_count <= mismatches;
		end
	end

endmodule

// ----- bench/indexed_list_insert_erase_top_test.sv -----
// Testbench top for the indexed list: clock, reset, command stimulus, watchdog and verdict.
`timescale 1ns / 100ps
module indexed_list_insert_erase_top_test;
	import ilie_pkg::*;

	localparam int RANDOM_OPS = 1200;
	localparam int STALL_LIMIT = 5000;

	typedef enum int {
		PHASE_GROW,
		PHASE_MIX,
		PHASE_SHRINK
	} phase_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [S_DATA_W-1:0] s_tdata = '0;
	logic [KIND_W-1:0] s_tuser = KIND_APPEND;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;
	int error_count;
	int outstanding;
	logic [COUNT_W-1:0] held_count;
	bit quiet = 1'b0;
	int idle_cycles = 0;

	indexed_list_insert_erase_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	list_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.error_count(error_count),
		.outstanding(outstanding),
		.held_count(held_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk)
		m_tready <= quiet || ($urandom_range(0, 99) >= 26);

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	task automatic issue_op(input kind_t op, input logic [INDEX_W-1:0] pos,
			input logic [VALUE_W-1:0] word);
		while (!quiet && $urandom_range(0, 99) < 26) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {2'b00, word, pos};
		do @(posedge clk); while (!s_tready);
	endtask

	function automatic kind_t pick_kind(phase_t ph);
		int r;
		r = $urandom_range(0, 99);
		case (ph)
			PHASE_GROW:
				return kind_t'(r < 45 ? KIND_APPEND : r < 85 ? KIND_INSERT :
					r < 92 ? KIND_READ : KIND_ERASE);
			PHASE_SHRINK:
				return kind_t'(r < 10 ? KIND_APPEND : r < 20 ? KIND_INSERT :
					r < 40 ? KIND_READ : KIND_ERASE);
			default:
				return kind_t'(r[1:0]);
		endcase
	endfunction

	function automatic logic [INDEX_W-1:0] pick_index();
		int top;
		top = held_count > 63 ? 63 : int'(held_count);
		if ($urandom_range(0, 4) == 0)
			return INDEX_W'($urandom);
		return INDEX_W'($urandom_range(0, top));
	endfunction

	function automatic logic [VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 19))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'h8000_0000;
			3: return 32'h7FFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		phase_t ph;
		int left_in_phase;
		int phase_no;
		kind_t op;
		ph = PHASE_GROW;
		left_in_phase = 120;
		phase_no = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty-list errors, then a list built at both ends and in the middle, read and erased.
		issue_op(KIND_READ, 6'd0, 32'h1111_1111);
		issue_op(KIND_ERASE, 6'd0, 32'h0);
		issue_op(KIND_INSERT, 6'd1, 32'h2222_2222);
		issue_op(KIND_INSERT, 6'd0, 32'h8000_0000);
		issue_op(KIND_APPEND, 6'd0, 32'h7FFF_FFFF);
		issue_op(KIND_INSERT, 6'd2, 32'h0000_0000);
		issue_op(KIND_INSERT, 6'd4, 32'h3333_3333);
		issue_op(KIND_INSERT, 6'd1, 32'hFFFF_FFFF);
		issue_op(KIND_READ, 6'd0, 32'h0);
		issue_op(KIND_READ, 6'd1, 32'h0);
		issue_op(KIND_READ, 6'd2, 32'h0);
		issue_op(KIND_READ, 6'd3, 32'h0);
		issue_op(KIND_READ, 6'd4, 32'h0);
		issue_op(KIND_READ, 6'd63, 32'hFFFF_FFFF);
		issue_op(KIND_ERASE, 6'd3, 32'h0);
		issue_op(KIND_ERASE, 6'd0, 32'h0);
		issue_op(KIND_ERASE, 6'd2, 32'h0);
		issue_op(KIND_APPEND, 6'd63, 32'h5555_5555);
		issue_op(KIND_INSERT, 6'd0, 32'hAAAA_AAAA);
		issue_op(KIND_READ, 6'd3, 32'h0);
		issue_op(KIND_READ, 6'd0, 32'h0);
		issue_op(KIND_ERASE, 6'd63, 32'h0);
		issue_op(KIND_APPEND, 6'd42, 32'd12345);
		issue_op(KIND_INSERT, 6'd63, 32'h0F0F_0F0F);
		issue_op(KIND_READ, 6'd4, 32'h0);

		for (int n = 0; n < RANDOM_OPS; n++) begin
			quiet = (n >= 500 && n < 700);
			if (left_in_phase == 0) begin
				phase_no++;
				case (phase_no % 4)
					0: ph = PHASE_GROW;
					2: ph = PHASE_SHRINK;
					default: ph = PHASE_MIX;
				endcase
				left_in_phase = ph == PHASE_GROW ? $urandom_range(80, 140) :
					$urandom_range(40, 120);
			end
			left_in_phase--;
			op = pick_kind(ph);
			issue_op(op, pick_index(), pick_value());
		end
		quiet = 1'b0;
		s_tvalid <= 1'b0;

		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/ilie_pkg.sv
rtl/ilie_cell.sv
rtl/indexed_list_insert_erase_top.sv
bench/list_checker.sv
bench/indexed_list_insert_erase_top_test.sv
